// ===== design/rmd160_pkg.sv =====
package rmd160_pkg;

   localparam int Steps = 80;

   typedef logic [31:0] word_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
      word_type e;
   } line_type;

   typedef word_type [15:0] block_type;

   localparam word_type Iv0 = 32'h67452301;
   localparam word_type Iv1 = 32'hEFCDAB89;
   localparam word_type Iv2 = 32'h98BADCFE;
   localparam word_type Iv3 = 32'h10325476;
   localparam word_type Iv4 = 32'hC3D2E1F0;
   localparam word_type PadWord = 32'h00000080;
   localparam word_type BitLen = 32'h00000100;

   localparam logic [3:0] Wl [80] = '{
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15,
      7, 4, 13, 1, 10, 6, 15, 3, 12, 0, 9, 5, 2, 14, 11, 8,
      3, 10, 14, 4, 9, 15, 8, 1, 2, 7, 0, 6, 13, 11, 5, 12,
      1, 9, 11, 10, 0, 8, 12, 4, 13, 3, 7, 15, 14, 5, 6, 2,
      4, 0, 5, 9, 7, 12, 2, 10, 14, 1, 3, 8, 11, 6, 15, 13};
   localparam logic [3:0] Wr [80] = '{
      5, 14, 7, 0, 9, 2, 11, 4, 13, 6, 15, 8, 1, 10, 3, 12,
      6, 11, 3, 7, 0, 13, 5, 10, 14, 15, 8, 12, 4, 9, 1, 2,
      15, 5, 1, 3, 7, 14, 6, 9, 11, 8, 12, 2, 10, 0, 4, 13,
      8, 6, 4, 1, 3, 11, 15, 0, 5, 12, 2, 13, 9, 7, 10, 14,
      12, 15, 10, 4, 1, 5, 8, 7, 6, 2, 13, 14, 0, 3, 9, 11};
   localparam logic [4:0] Sl [80] = '{
      11, 14, 15, 12, 5, 8, 7, 9, 11, 13, 14, 15, 6, 7, 9, 8,
      7, 6, 8, 13, 11, 9, 7, 15, 7, 12, 15, 9, 11, 7, 13, 12,
      11, 13, 6, 7, 14, 9, 13, 15, 14, 8, 13, 6, 5, 12, 7, 5,
      11, 12, 14, 15, 14, 15, 9, 8, 9, 14, 5, 6, 8, 6, 5, 12,
      9, 15, 5, 11, 6, 8, 13, 12, 5, 12, 13, 14, 11, 8, 5, 6};
   localparam logic [4:0] Sr [80] = '{
      8, 9, 9, 11, 13, 15, 15, 5, 7, 7, 8, 11, 14, 14, 12, 6,
      9, 13, 15, 7, 12, 8, 9, 11, 7, 7, 12, 7, 6, 15, 13, 11,
      9, 7, 15, 11, 8, 6, 6, 14, 12, 13, 5, 14, 13, 13, 7, 5,
      15, 5, 8, 11, 14, 14, 6, 14, 6, 9, 12, 9, 12, 5, 15, 8,
      8, 5, 12, 9, 12, 5, 14, 6, 8, 13, 6, 5, 15, 13, 11, 11};

   localparam word_type Kl [5] = '{32'h00000000, 32'h5A827999, 32'h6ED9EBA1,
                                   32'h8F1BBCDC, 32'hA953FD4E};
   localparam word_type Kr [5] = '{32'h50A28BE6, 32'h5C4DD124, 32'h6D703EF3,
                                   32'h7A6D76E9, 32'h00000000};

   function automatic word_type rol(input word_type x, input logic [4:0] n);
      logic [63:0] dbl;
      dbl = {x, x} << n;
      return dbl[63:32];
   endfunction

   function automatic word_type bfun(input logic [2:0] g, input word_type x,
                                     input word_type y, input word_type z);
      word_type r;
      case (g)
         3'd0: r = x ^ y ^ z;
         3'd1: r = (x & y) | (~x & z);
         3'd2: r = (x | ~y) ^ z;
         3'd3: r = (x & z) | (y & ~z);
         default: r = x ^ (y | ~z);
      endcase
      return r;
   endfunction

   function automatic line_type step_left(input line_type s, input block_type m,
                                          input int j);
      line_type o;
      logic [2:0] g;
      g = 3'(j / 16);
      o.a = s.e;
      o.e = s.d;
      o.d = rol(s.c, 5'd10);
      o.c = s.b;
      o.b = rol(s.a + bfun(g, s.b, s.c, s.d) + m[Wl[j]] + Kl[g], Sl[j]) + s.e;
      return o;
   endfunction

   function automatic line_type step_right(input line_type s, input block_type m,
                                           input int j);
      line_type o;
      logic [2:0] g;
      g = 3'(j / 16);
      o.a = s.e;
      o.e = s.d;
      o.d = rol(s.c, 5'd10);
      o.c = s.b;
      o.b = rol(s.a + bfun(3'd4 - g, s.b, s.c, s.d) + m[Wr[j]] + Kr[g], Sr[j]) + s.e;
      return o;
   endfunction

endpackage

// ===== design/ripemd160_of_32_byte_digest_top.sv =====
// pipeline: 80 step stages followed by an output stage that registers the digest
// throughput: one transaction per cycle; each of the 80 rounds of both lines has its own stage
// a stall holds the whole pipeline; the output register frees as it is taken
// reset: synchronous, active high, clears all valid bits; data registers are not reset
module ripemd160_of_32_byte_digest_top
   import rmd160_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_in_word0,
   input  logic [31:0] req_in_word1,
   input  logic [31:0] req_in_word2,
   input  logic [31:0] req_in_word3,
   input  logic [31:0] req_in_word4,
   input  logic [31:0] req_in_word5,
   input  logic [31:0] req_in_word6,
   input  logic [31:0] req_in_word7,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word0,
   output logic [31:0] rsp_digest_word1,
   output logic [31:0] rsp_digest_word2,
   output logic [31:0] rsp_digest_word3,
   output logic [31:0] rsp_digest_word4
);

   line_type  left_ff  [Steps];
   line_type  right_ff [Steps];
   block_type msg_ff   [Steps];
   logic [Steps-1:0] vld_ff;
   logic      out_vld_ff;
   word_type  dig_ff [5];
   logic      adv;
   block_type msg_in;
   line_type  iv;
   line_type  fl;
   line_type  fr;

   assign rsp_valid = out_vld_ff;
   assign adv = !out_vld_ff || rsp_ready;
   assign req_ready = adv;

   always_comb begin
      msg_in = '0;
      msg_in[0] = req_in_word0;
      msg_in[1] = req_in_word1;
      msg_in[2] = req_in_word2;
      msg_in[3] = req_in_word3;
      msg_in[4] = req_in_word4;
      msg_in[5] = req_in_word5;
      msg_in[6] = req_in_word6;
      msg_in[7] = req_in_word7;
      msg_in[8] = PadWord;
      msg_in[14] = BitLen;
      iv = '{a: Iv0, b: Iv1, c: Iv2, d: Iv3, e: Iv4};
      fl = left_ff[Steps-1];
      fr = right_ff[Steps-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= {vld_ff[Steps-2:0], req_valid};
         out_vld_ff <= vld_ff[Steps-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         left_ff[0]  <= step_left(iv, msg_in, 0);
         right_ff[0] <= step_right(iv, msg_in, 0);
         msg_ff[0]   <= msg_in;
         for (int j = 1; j < Steps; j++) begin
            left_ff[j]  <= step_left(left_ff[j-1], msg_ff[j-1], j);
            right_ff[j] <= step_right(right_ff[j-1], msg_ff[j-1], j);
            msg_ff[j]   <= msg_ff[j-1];
         end
         dig_ff[0] <= Iv1 + fl.c + fr.d;
         dig_ff[1] <= Iv2 + fl.d + fr.e;
         dig_ff[2] <= Iv3 + fl.e + fr.a;
         dig_ff[3] <= Iv4 + fl.a + fr.b;
         dig_ff[4] <= Iv0 + fl.b + fr.c;
      end
   end

   assign rsp_digest_word0 = dig_ff[0];
   assign rsp_digest_word1 = dig_ff[1];
   assign rsp_digest_word2 = dig_ff[2];
   assign rsp_digest_word3 = dig_ff[3];
   assign rsp_digest_word4 = dig_ff[4];

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("pipeline advanced while result stalled");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_digest_word0))
      else $error("stalled result changed");
   assert property (@(posedge clock) disable iff (reset)
      (adv && vld_ff[Steps-1]) |=> rsp_valid)
      else $error("result lost at output stage");

endmodule

// ===== tb/tb.sv =====
module tb;
   import rmd160_pkg::*;

   localparam int Latency = 81;
   localparam int RandomCount = 650;
   localparam int WatchdogLimit = 4000;

   typedef struct {
      word_type w [8];
   } message_type;

   typedef struct {
      word_type h [5];
   } digest_type;

   typedef struct {
      message_type msg;
      bit          known;
      digest_type  dig;
   } vector_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_in_word0, req_in_word1, req_in_word2, req_in_word3;
   logic [31:0] req_in_word4, req_in_word5, req_in_word6, req_in_word7;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_digest_word0, rsp_digest_word1, rsp_digest_word2;
   logic [31:0] rsp_digest_word3, rsp_digest_word4;

   digest_type pending_digests [$];
   int         error_count;
   int         idle_cycles;
   bit         stimulus_done;

   ripemd160_of_32_byte_digest_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_in_word0(req_in_word0), .req_in_word1(req_in_word1),
      .req_in_word2(req_in_word2), .req_in_word3(req_in_word3),
      .req_in_word4(req_in_word4), .req_in_word5(req_in_word5),
      .req_in_word6(req_in_word6), .req_in_word7(req_in_word7),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_digest_word0(rsp_digest_word0), .rsp_digest_word1(rsp_digest_word1),
      .rsp_digest_word2(rsp_digest_word2), .rsp_digest_word3(rsp_digest_word3),
      .rsp_digest_word4(rsp_digest_word4)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic word_type rotl(word_type x, int n);
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic word_type mix(int g, word_type x, word_type y, word_type z);
      case (g)
         0: return x ^ y ^ z;
         1: return (x & y) | (~x & z);
         2: return (x | ~y) ^ z;
         3: return (x & z) | (y & ~z);
         default: return x ^ (y | ~z);
      endcase
   endfunction

   function automatic digest_type hash_message(message_type msg);
      word_type   blk [16];
      word_type   la, lb, lc, ld, le, ra, rb, rc, rd, re, t;
      digest_type d;
      int         g;
      for (int i = 0; i < 16; i++) blk[i] = '0;
      for (int i = 0; i < 8; i++) blk[i] = msg.w[i];
      blk[8] = 32'h80;
      blk[14] = 32'd256;
      la = Iv0; lb = Iv1; lc = Iv2; ld = Iv3; le = Iv4;
      ra = Iv0; rb = Iv1; rc = Iv2; rd = Iv3; re = Iv4;
      for (int j = 0; j < 80; j++) begin
         g = j / 16;
         t = rotl(la + mix(g, lb, lc, ld) + blk[Wl[j]] + Kl[g], int'(Sl[j])) + le;
         la = le; le = ld; ld = rotl(lc, 10); lc = lb; lb = t;
         t = rotl(ra + mix(4 - g, rb, rc, rd) + blk[Wr[j]] + Kr[g], int'(Sr[j])) + re;
         ra = re; re = rd; rd = rotl(rc, 10); rc = rb; rb = t;
      end
      d.h[0] = Iv1 + lc + rd;
      d.h[1] = Iv2 + ld + re;
      d.h[2] = Iv3 + le + ra;
      d.h[3] = Iv4 + la + rb;
      d.h[4] = Iv0 + lb + rc;
      return d;
   endfunction

   task automatic report(string what, int idx, word_type got, word_type want);
      $display("mismatch %s word %0d: got %h expected %h", what, idx, got, want);
      error_count++;
   endtask

   task automatic send_message(message_type msg, bit known, digest_type dig);
      int gap;
      gap = $urandom_range(0, 7);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pending_digests.push_back(known ? dig : hash_message(msg));
      req_valid <= 1'b1;
      req_in_word0 <= msg.w[0]; req_in_word1 <= msg.w[1];
      req_in_word2 <= msg.w[2]; req_in_word3 <= msg.w[3];
      req_in_word4 <= msg.w[4]; req_in_word5 <= msg.w[5];
      req_in_word6 <= msg.w[6]; req_in_word7 <= msg.w[7];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic message_type fill(word_type v);
      message_type m;
      for (int i = 0; i < 8; i++) m.w[i] = v;
      return m;
   endfunction

   initial begin
      vector_type  vectors [$];
      vector_type  v;
      message_type m;
      digest_type  none;
      int          burst;

      for (int i = 0; i < 5; i++) none.h[i] = '0;
      reset = 1'b1;
      req_valid = 1'b0;
      {req_in_word0, req_in_word1, req_in_word2, req_in_word3} = '0;
      {req_in_word4, req_in_word5, req_in_word6, req_in_word7} = '0;
      error_count = 0;
      stimulus_done = 1'b0;

      // 32-byte messages: 32 zero bytes, uniform word fills, and one word set or cleared
      v.known = 1'b0; v.dig = none;
      v.msg = fill(32'h0); vectors.push_back(v);
      v.msg = fill(32'hffffffff); vectors.push_back(v);
      v.msg = fill(32'h80000000); vectors.push_back(v);
      v.msg = fill(32'h00000001); vectors.push_back(v);
      v.msg = fill(32'haaaaaaaa); vectors.push_back(v);
      v.msg = fill(32'h55555555); vectors.push_back(v);
      for (int i = 0; i < 8; i++) begin
         v.msg = fill(32'h0); v.msg.w[i] = 32'hffffffff; vectors.push_back(v);
         v.msg = fill(32'hffffffff); v.msg.w[i] = 32'h0; vectors.push_back(v);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (vectors[i]) send_message(vectors[i].msg, vectors[i].known, vectors[i].dig);

      for (int n = 0; n < RandomCount; n++) begin
         for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 5))
               0: m.w[i] = 32'h0;
               1: m.w[i] = 32'hffffffff;
               2: m.w[i] = 32'h1 << $urandom_range(0, 31);
               default: m.w[i] = $urandom;
            endcase
         end
         if (n == RandomCount / 2) begin
            // drain everything before continuing
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_digests.size() != 0) @(posedge clock);
         end
         send_message(m, 1'b0, none);
         if ($urandom_range(0, 20) == 0) begin
            burst = $urandom_range(10, 40);
            for (int b = 0; b < burst; b++) begin
               for (int i = 0; i < 8; i++) m.w[i] = $urandom;
               pending_digests.push_back(hash_message(m));
               req_valid <= 1'b1;
               req_in_word0 <= m.w[0]; req_in_word1 <= m.w[1];
               req_in_word2 <= m.w[2]; req_in_word3 <= m.w[3];
               req_in_word4 <= m.w[4]; req_in_word5 <= m.w[5];
               req_in_word6 <= m.w[6]; req_in_word7 <= m.w[7];
               @(posedge clock);
               while (!req_ready) @(posedge clock);
            end
         end
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ready <= 1'b0;
         end else begin
            if (rsp_valid && rsp_ready)
               stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            rsp_ready <= (stall == 0);
         end
      end
   end

   always @(posedge clock) begin
      digest_type want;
      word_type   got [5];
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_digest_word0, rsp_digest_word1, rsp_digest_word2,
                 rsp_digest_word3, rsp_digest_word4};
         if (pending_digests.size() == 0) begin
            report("unexpected transaction", 0, got[0], '0);
         end else begin
            want = pending_digests.pop_front();
            for (int i = 0; i < 5; i++)
               if (got[i] !== want.h[i]) report("digest", i, got[i], want.h[i]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog expired with %0d outstanding", pending_digests.size());
            $display("tb: done, errors");
            $finish;
         end
         if (stimulus_done && pending_digests.size() == 0) begin
            repeat (Latency + 10) @(posedge clock);
            if (error_count == 0 && pending_digests.size() == 0) begin
               $display("tb: done, clean");
            end else begin
               $display("tb: done, errors");
            end
            $finish;
         end
      end
   end

endmodule
